// ===== hdl/kset_pkg.sv =====
package kset_pkg;

	localparam int unsigned DEF_TABLE_DEPTH = 16;
	localparam int unsigned DEF_POS_BITS    = 4;
	localparam int unsigned DEF_CNT_BITS    = 5;

	localparam int unsigned ACT_BITS    = 2;
	localparam int unsigned ID_BITS     = 4;
	localparam int unsigned START_BITS  = 5;
	localparam int unsigned PERIOD_BITS = 7;
	localparam int unsigned CAP_BITS    = 5;

	// common width for comparing counts, positions and the capacity
	localparam int unsigned WIDE_W = 8;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic [ACT_BITS-1:0] {
		ACT_ADD     = 2'd0,
		ACT_REM_KEY = 2'd1,
		ACT_REM_ID  = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_BITS-1:0]     id;
		logic [START_BITS-1:0]  start;
		logic [PERIOD_BITS-1:0] period;
	} entry_t;

	typedef struct packed {
		logic ready;
		logic scan;
		logic fetch;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic req_is_read;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/kset_req_if.sv =====
interface kset_req_if #(parameter int unsigned POS_W = kset_pkg::DEF_POS_BITS);
	import kset_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [ACT_BITS-1:0]    action;
	logic [ID_BITS-1:0]     entry_id;
	logic [START_BITS-1:0]  start_slot;
	logic [PERIOD_BITS-1:0] period_value;
	logic [POS_W-1:0]       position;

	modport source (
		output valid, action, entry_id, start_slot, period_value, position,
		input  ready
	);
	modport sink (
		input  valid, action, entry_id, start_slot, period_value, position,
		output ready
	);
endinterface

// ===== hdl/kset_rsp_if.sv =====
interface kset_rsp_if #(parameter int unsigned CNT_W = kset_pkg::DEF_CNT_BITS);
	import kset_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CNT_W-1:0]       changed_count;
	logic [CNT_W-1:0]       entry_count;
	logic                   table_full;
	logic [ID_BITS-1:0]     read_id;
	logic [START_BITS-1:0]  read_start;
	logic [PERIOD_BITS-1:0] read_period;
	logic                   read_valid;

	modport source (
		output valid, changed_count, entry_count, table_full,
		output read_id, read_start, read_period, read_valid,
		input  ready
	);
	modport sink (
		input  valid, changed_count, entry_count, table_full,
		input  read_id, read_start, read_period, read_valid,
		output ready
	);
endinterface

// ===== hdl/kset_cfg_if.sv =====
interface kset_cfg_if;
	import kset_pkg::*;

	logic                valid;
	logic                ready;
	logic [CAP_BITS-1:0] capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink (input valid, capacity_limit, output ready);
endinterface

// ===== hdl/kset_ctrl.sv =====
module kset_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kset_pkg::dp_status_t  status,
	output kset_pkg::ctrl_cmd_t   cmd
);
	import kset_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.req_valid) begin
					state_d = status.req_is_read ? ST_FETCH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FETCH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.ready  = 1'b1;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_FETCH:  cmd.fetch  = 1'b1;
			ST_FINISH: cmd.finish = status.out_free;
			default:   cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ready && status.req_valid) |=> (state_q != ST_IDLE))
		else $error("accepted transfer did not start an action");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !status.out_free) |=> (state_q == ST_FINISH))
		else $error("result dropped while output register busy");
`endif

endmodule

// ===== hdl/kset_dp.sv =====
module kset_dp #(
	parameter int unsigned TABLE_DEPTH = kset_pkg::DEF_TABLE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	kset_req_if.sink             req,
	kset_rsp_if.source           rsp,
	kset_cfg_if.sink             cfg,
	input  kset_pkg::ctrl_cmd_t  cmd,
	output kset_pkg::dp_status_t status
);
	import kset_pkg::*;

	localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];

	// latched request
	action_t                act_q;
	logic [ID_BITS-1:0]     id_q;
	logic [START_BITS-1:0]  start_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [AW-1:0]          pos_q;
	logic                   pos_ok_q;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    r_q;
	logic [CNT_W-1:0]    w_q;
	logic                found_q;
	logic                rd_valid_s1;
	entry_t              rd_data_s1;
	logic [CAP_BITS-1:0] cap_q;

	logic                   out_valid_q;
	logic [CNT_W-1:0]       out_changed_q;
	logic [CNT_W-1:0]       out_count_q;
	logic                   out_full_q;
	entry_t                 out_entry_q;
	logic                   out_rvalid_q;

	logic                accept;
	logic [WIDE_W-1:0]   pos_w;
	logic [WIDE_W-1:0]   cnt_w;
	logic [WIDE_W-1:0]   cap_w;
	logic [WIDE_W-1:0]   eff_cap;
	logic                pos_ok;
	logic                issue;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                proc;
	logic                key_hit;
	logic                id_hit;
	logic                drop;
	logic                upd;
	logic                append;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;
	logic [CNT_W-1:0]    new_count;
	logic [CNT_W-1:0]    changed;

	assign accept  = cmd.ready && req.valid;
	assign pos_w   = WIDE_W'(req.position);
	assign cnt_w   = WIDE_W'(count_q);
	assign pos_ok  = (pos_w < cnt_w) && (pos_w < DEPTH_W);
	assign cap_w   = WIDE_W'(cap_q);
	assign eff_cap = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;

	assign status.req_valid   = req.valid;
	assign status.req_is_read = (action_t'(req.action) == ACT_READ);
	assign status.scan_done   = (r_q >= count_q) && !rd_valid_s1;
	assign status.out_free    = !out_valid_q || rsp.ready;

	assign req.ready = cmd.ready;
	assign cfg.ready = 1'b1;

	// read side: one entry per cycle while scanning, or the addressed entry on a read
	assign issue   = cmd.scan && (r_q < count_q);
	assign rd_en   = issue || (cmd.fetch && pos_ok_q);
	assign rd_addr = cmd.fetch ? pos_q : r_q[AW-1:0];

	// compare stage on the entry read in the previous cycle
	assign proc    = cmd.scan && rd_valid_s1;
	assign key_hit = (rd_data_s1.id == id_q) && (rd_data_s1.start == start_q);
	assign id_hit  = (rd_data_s1.id == id_q);
	assign append  = (act_q == ACT_ADD) && !found_q && (cnt_w < eff_cap);

	always_comb begin
		drop = 1'b0;
		upd  = 1'b0;
		unique case (act_q)
			ACT_ADD:     upd  = key_hit && !found_q;
			ACT_REM_KEY: drop = key_hit && !found_q;
			ACT_REM_ID:  drop = id_hit;
			ACT_READ:    drop = 1'b0;
			default:     drop = 1'b0;
		endcase
	end

	// survivors are written back at w_q, which never passes the read pointer
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = w_q[AW-1:0];
		wr_data = rd_data_s1;
		if (cmd.finish) begin
			wr_en   = append;
			wr_addr = count_q[AW-1:0];
			wr_data = '{id: id_q, start: start_q, period: period_q};
		end else if (proc) begin
			if (act_q == ACT_ADD) begin
				wr_en          = upd;
				wr_data.period = period_q;
			end else begin
				wr_en = !drop;
			end
		end
	end

	always_comb begin
		unique case (act_q)
			ACT_ADD: begin
				new_count = append ? count_q + CNT_W'(1) : count_q;
				changed   = append ? CNT_W'(1) : '0;
			end
			ACT_REM_KEY, ACT_REM_ID: begin
				new_count = w_q;
				changed   = count_q - w_q;
			end
			ACT_READ: begin
				new_count = count_q;
				changed   = '0;
			end
			default: begin
				new_count = count_q;
				changed   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action_t'(req.action);
			id_q     <= req.entry_id;
			start_q  <= req.start_slot;
			period_q <= req.period_value;
			pos_q    <= pos_w[AW-1:0];
			pos_ok_q <= pos_ok;
		end
		if (cmd.finish) begin
			out_changed_q <= changed;
			out_count_q   <= new_count;
			out_full_q    <= (WIDE_W'(new_count) >= eff_cap);
			out_rvalid_q  <= (act_q == ACT_READ) && pos_ok_q;
			out_entry_q   <= ((act_q == ACT_READ) && pos_ok_q) ? rd_data_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			r_q         <= '0;
			w_q         <= '0;
			found_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (accept) begin
				r_q     <= '0;
				w_q     <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					r_q <= r_q + CNT_W'(1);
				end
				if (proc) begin
					found_q <= found_q || upd || drop;
					if (!drop) begin
						w_q <= w_q + CNT_W'(1);
					end
				end
			end
			if (cmd.finish) begin
				count_q <= new_count;
			end
			if (cfg.valid) begin
				cap_q <= cfg.capacity_limit;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.changed_count = DEF_CNT_BITS'(out_changed_q);
	assign rsp.entry_count   = DEF_CNT_BITS'(out_count_q);
	assign rsp.table_full    = out_full_q;
	assign rsp.read_id       = out_entry_q.id;
	assign rsp.read_start    = out_entry_q.start;
	assign rsp.read_period   = out_entry_q.period;
	assign rsp.read_valid    = out_rvalid_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> ((w_q <= r_q) && (r_q <= count_q)))
		else $error("compaction write pointer overtook read pointer");
`endif

endmodule

// ===== hdl/keyed_schedule_entry_table.sv =====
// Order: add and both removes scan the N entries in use between transfer in and result;
// a read fetches the addressed entry instead; a result held back stalls the next action.
// Flow: one action at a time, no new transfer in before the last one finishes; the
// scan reads one entry per cycle and writes survivors back behind it in the same pass.
// Reset: table empty, capacity 16, no result pending; table contents are not cleared.
module keyed_schedule_entry_table #(
	parameter int unsigned TABLE_DEPTH = kset_pkg::DEF_TABLE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	kset_req_if.sink   req,
	kset_rsp_if.source rsp,
	kset_cfg_if.sink   cfg
);
	import kset_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	kset_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	kset_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule
